// ----- design/timeval_arithmetic_unit_defines.svh -----
// Assertion macros shared by the time value arithmetic unit.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TIMEVAL_ARITHMETIC_UNIT_DEFINES_SVH
`define TIMEVAL_ARITHMETIC_UNIT_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define TVA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define TVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tva_pkg.sv -----
// Shared widths and codes of the time value arithmetic unit.
// No dependencies; used by the channel interfaces and the top level.
package tva_pkg;

  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int FACTOR_W = 31;
  localparam int ACT_W    = 2;
  localparam int CODE_W   = 2;

  localparam int unsigned USEC_PER_SEC = 1000000;

  localparam logic [ACT_W-1:0] ACT_CMP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DIV = 2'd2;

  localparam logic [CODE_W-1:0] ORD_EQUAL   = 2'd0;
  localparam logic [CODE_W-1:0] ORD_EARLIER = 2'd1;
  localparam logic [CODE_W-1:0] ORD_LATER   = 2'd2;

  localparam logic [CODE_W-1:0] ST_OK       = 2'd0;
  localparam logic [CODE_W-1:0] ST_DIVZERO  = 2'd1;
  localparam logic [CODE_W-1:0] ST_SATURATE = 2'd2;

endpackage

// ----- design/tva_if.sv -----
// Request and response channel interfaces of the time value arithmetic unit.
// Depends on tva_pkg for field widths.
interface tva_req_if import tva_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           action;
  logic signed [SEC_W-1:0]    a_sec;
  logic [USEC_W-1:0]          a_usec;
  logic signed [SEC_W-1:0]    b_sec;
  logic [USEC_W-1:0]          b_usec;
  logic [FACTOR_W-1:0]        factor;

  modport source (output valid, action, a_sec, a_usec, b_sec, b_usec, factor, input ready);
  modport sink (input valid, action, a_sec, a_usec, b_sec, b_usec, factor, output ready);
endinterface

interface tva_rsp_if import tva_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SEC_W-1:0]    res_sec;
  logic [USEC_W-1:0]          res_usec;
  logic [CODE_W-1:0]          order;
  logic [CODE_W-1:0]          status;

  modport source (output valid, res_sec, res_usec, order, status, input ready);
  modport sink (input valid, res_sec, res_usec, order, status, output ready);
endinterface

// ----- design/tva_divpipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instantiated by the time value arithmetic unit top level.
module tva_divpipe #(
  parameter int NUM_W  = 51,
  parameter int DEN_W  = 31,
  parameter int QUOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUOT_W-1:0] quot,
  output logic [DEN_W-1:0]  rem,
  output logic [DEN_W-1:0]  den_out,
  output logic [SIDE_W-1:0] side_out
);

  // The caller guarantees that num shifted right by QUOT_W is below den,
  // so the quotient fits in QUOT_W bits.
  logic              v  [QUOT_W+1];
  logic [DEN_W-1:0]  r  [QUOT_W+1];
  logic [QUOT_W-1:0] qr [QUOT_W+1];
  logic [DEN_W-1:0]  d  [QUOT_W+1];
  logic [SIDE_W-1:0] s  [QUOT_W+1];

  assign v[0]  = in_valid;
  assign r[0]  = DEN_W'(num >> QUOT_W);
  assign qr[0] = num[QUOT_W-1:0];
  assign d[0]  = den;
  assign s[0]  = side_in;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    always_comb begin
      trial = {r[k], qr[k][QUOT_W-1]};
      take  = trial >= {1'b0, d[k]};
      diff  = trial - {1'b0, d[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    // The high part of qr holds the dividend bits not yet used and the
    // quotient bits fill in from the bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qr[k+1] <= {qr[k][QUOT_W-2:0], take};
        d[k+1]  <= d[k];
        s[k+1]  <= s[k];
      end
    end
  end

  assign out_valid = v[QUOT_W];
  assign quot      = qr[QUOT_W];
  assign rem       = r[QUOT_W];
  assign den_out   = d[QUOT_W];
  assign side_out  = s[QUOT_W];

endmodule

// ----- design/timeval_arithmetic_unit.sv -----
// Time value arithmetic unit: compare, multiply and divide on seconds/microseconds.
// Depends on tva_pkg, tva_if.sv, tva_divpipe and the assertion macro header.
//
// Usage:
//   req carries one request per valid/ready handshake: an action code, two
//   times (a_sec/a_usec, b_sec/b_usec) and an unsigned factor. rsp returns
//   exactly one response per request, in request order: res_sec, res_usec,
//   order and status.
//   Throughput is one request per cycle while rsp does not stall, set by the
//   pipeline: an input stage, two parallel 32-stage dividers for the seconds
//   quotient and for microseconds over factor, a multiply stage, a third
//   32-stage divider for the microsecond part, and two finishing stages.
//   A skid register behind the output stage absorbs one response when rsp
//   stalls; while it is full the pipeline holds and req.ready is low. No
//   response is lost or repeated under any stall pattern.
//   Reset (rst, synchronous) clears all valid bits; req.ready is high in the
//   first cycle after reset. The block keeps no state between requests.
`include "timeval_arithmetic_unit_defines.svh"

module timeval_arithmetic_unit import tva_pkg::*; (
  input  logic clk,
  input  logic rst,
  tva_req_if.sink   req,
  tva_rsp_if.source rsp
);

  localparam int NUM2_W = USEC_W + FACTOR_W;
  localparam int QUOT_W = 32;
  localparam int RU_W   = USEC_W + 3;

  localparam logic signed [63:0] SEC_HI = 64'sd2147483647;
  localparam logic signed [63:0] SEC_LO = -64'sd2147483648;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic              neg;
    logic [SEC_W-1:0]  a_sec;
    logic [USEC_W-1:0] a_usec;
    logic [CODE_W-1:0] order;
  } d1_side_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               neg;
    logic [QUOT_W-1:0]  q1;
    logic [USEC_W-1:0]  q3;
    logic               zero;
    logic [CODE_W-1:0]  order;
    logic signed [63:0] prod;
  } m_side_t;

  typedef struct packed {
    logic signed [SEC_W-1:0] res_sec;
    logic [USEC_W-1:0]       res_usec;
    logic [CODE_W-1:0]       order;
    logic [CODE_W-1:0]       status;
  } res_t;

  logic en;
  logic k_valid;
  res_t k_res;
  logic o_valid;
  res_t o_res;

  assign en        = !k_valid;
  assign req.ready = en;

  // Input stage: compare and seconds magnitude.
  logic                 s1_valid;
  d1_side_t             s1_side;
  logic [FACTOR_W-1:0]  s1_n;
  logic [SEC_W-1:0]     s1_mag;
  logic [CODE_W-1:0]    order_c;

  always_comb begin
    if (req.a_sec < req.b_sec || (req.a_sec == req.b_sec && req.a_usec < req.b_usec)) begin
      order_c = ORD_EARLIER;
    end else if (req.a_sec > req.b_sec || req.a_usec > req.b_usec) begin
      order_c = ORD_LATER;
    end else begin
      order_c = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.action <= req.action;
      s1_side.neg    <= req.a_sec[SEC_W-1];
      s1_side.a_sec  <= req.a_sec;
      s1_side.a_usec <= req.a_usec;
      s1_side.order  <= order_c;
      s1_n           <= req.factor;
      s1_mag         <= req.a_sec[SEC_W-1] ? (~req.a_sec + 1'b1) : req.a_sec;
    end
  end

  // Seconds quotient and remainder, plus microseconds over factor in parallel.
  logic                d1_valid;
  logic [QUOT_W-1:0]   q1;
  logic [FACTOR_W-1:0] r1;
  logic [FACTOR_W-1:0] d1_den;
  d1_side_t            d1_side;
  logic                d3_valid;
  logic [QUOT_W-1:0]   q3;
  logic                d3_zero;

  tva_divpipe #(
    .NUM_W (SEC_W),
    .DEN_W (FACTOR_W),
    .QUOT_W(QUOT_W),
    .SIDE_W($bits(d1_side_t))
  ) u_div_sec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_valid),
    .num      (s1_mag),
    .den      (s1_n),
    .side_in  (s1_side),
    .out_valid(d1_valid),
    .quot     (q1),
    .rem      (r1),
    .den_out  (d1_den),
    .side_out (d1_side)
  );

  tva_divpipe #(
    .NUM_W (QUOT_W),
    .DEN_W (FACTOR_W),
    .QUOT_W(QUOT_W),
    .SIDE_W(1)
  ) u_div_usec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_valid),
    .num      (QUOT_W'(s1_side.a_usec)),
    .den      (s1_n),
    .side_in  (s1_n == '0),
    .out_valid(d3_valid),
    .quot     (q3),
    .rem      (),
    .den_out  (),
    .side_out (d3_zero)
  );

  // Multiply stage: seconds product, and the dividend for the microsecond-part divider.
  logic                m_valid;
  m_side_t             m_side;
  logic [NUM2_W-1:0]   m_num;
  logic [FACTOR_W-1:0] m_den;
  logic signed [63:0]  prod_c;
  logic [NUM2_W-1:0]   num_mul_c;
  logic [NUM2_W-1:0]   num_div_c;

  always_comb begin
    prod_c    = $signed(d1_side.a_sec) * $signed({1'b0, d1_den});
    num_mul_c = NUM2_W'(d1_side.a_usec) * NUM2_W'(d1_den);
    num_div_c = NUM2_W'(r1) * NUM2_W'(USEC_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side.action <= d1_side.action;
      m_side.neg    <= d1_side.neg;
      m_side.q1     <= q1;
      m_side.q3     <= q3[USEC_W-1:0];
      m_side.zero   <= d3_zero;
      m_side.order  <= d1_side.order;
      m_side.prod   <= prod_c;
      m_num         <= (d1_side.action == ACT_MUL) ? num_mul_c : num_div_c;
      m_den         <= (d1_side.action == ACT_MUL) ? FACTOR_W'(USEC_PER_SEC) : d1_den;
    end
  end

  // Microsecond part: product over one million, or scaled remainder over factor.
  logic                d2_valid;
  logic [QUOT_W-1:0]   q2;
  logic [FACTOR_W-1:0] r2;
  logic [FACTOR_W-1:0] d2_den;
  m_side_t             d2_side;

  tva_divpipe #(
    .NUM_W (NUM2_W),
    .DEN_W (FACTOR_W),
    .QUOT_W(QUOT_W),
    .SIDE_W($bits(m_side_t))
  ) u_div_frac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .num      (m_num),
    .den      (m_den),
    .side_in  (m_side),
    .out_valid(d2_valid),
    .quot     (q2),
    .rem      (r2),
    .den_out  (d2_den),
    .side_out (d2_side)
  );

  // Combine stage: raw seconds and signed microseconds before normalizing.
  logic                    f_valid;
  logic [ACT_W-1:0]        f_action;
  logic                    f_zero;
  logic [CODE_W-1:0]       f_order;
  logic signed [63:0]      f_sec;
  logic signed [RU_W-1:0]  f_usec;
  logic signed [63:0]      sec_c;
  logic signed [RU_W-1:0]  usec_c;
  logic signed [RU_W-1:0]  frac_c;

  always_comb begin
    frac_c = d2_side.neg ? -$signed(RU_W'(q2)) : $signed(RU_W'(q2));
    if (d2_side.action == ACT_MUL) begin
      sec_c  = d2_side.prod + $signed(64'(q2));
      usec_c = $signed(RU_W'(r2));
    end else begin
      sec_c  = d2_side.neg ? -$signed(64'(d2_side.q1)) : $signed(64'(d2_side.q1));
      usec_c = frac_c + $signed(RU_W'(d2_side.q3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_action <= d2_side.action;
      f_zero   <= d2_side.zero;
      f_order  <= d2_side.order;
      f_sec    <= sec_c;
      f_usec   <= usec_c;
    end
  end

  // Output stage: carry or borrow one second, then saturate or flag a zero divisor; compares return only the order.
  res_t                   res_c;
  logic signed [63:0]     sec_adj;
  logic signed [RU_W-1:0] usec_adj;

  always_comb begin
    if (f_usec >= $signed(RU_W'(USEC_PER_SEC))) begin
      sec_adj  = f_sec + 64'sd1;
      usec_adj = f_usec - $signed(RU_W'(USEC_PER_SEC));
    end else if (f_usec < 0) begin
      sec_adj  = f_sec - 64'sd1;
      usec_adj = f_usec + $signed(RU_W'(USEC_PER_SEC));
    end else begin
      sec_adj  = f_sec;
      usec_adj = f_usec;
    end

    res_c = '0;
    unique case (f_action) inside
      ACT_CMP: begin
        res_c.order = f_order;
      end
      ACT_MUL, ACT_DIV: begin
        if (f_action == ACT_DIV && f_zero) begin
          res_c.status = ST_DIVZERO;
        end else if (sec_adj > SEC_HI) begin
          res_c.res_sec  = SEC_HI[SEC_W-1:0];
          res_c.res_usec = USEC_W'(USEC_PER_SEC - 1);
          res_c.status   = ST_SATURATE;
        end else if (sec_adj < SEC_LO) begin
          res_c.res_sec  = SEC_LO[SEC_W-1:0];
          res_c.status   = ST_SATURATE;
        end else begin
          res_c.res_sec  = sec_adj[SEC_W-1:0];
          res_c.res_usec = usec_adj[USEC_W-1:0];
          res_c.status   = ST_OK;
        end
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_res <= res_c;
    end
  end

  // Skid register: takes the output stage's response when the receiver stalls,
  // so the pipeline can move on by one before it has to hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (k_valid) begin
      if (rsp.ready) begin
        k_valid <= 1'b0;
      end
    end else if (o_valid && !rsp.ready) begin
      k_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!k_valid) begin
      k_res <= o_res;
    end
  end

  assign rsp.valid    = k_valid || o_valid;
  assign rsp.res_sec  = k_valid ? k_res.res_sec  : o_res.res_sec;
  assign rsp.res_usec = k_valid ? k_res.res_usec : o_res.res_usec;
  assign rsp.order    = k_valid ? k_res.order    : o_res.order;
  assign rsp.status   = k_valid ? k_res.status   : o_res.status;

  `TVA_ASSERT_ALWAYS(a_lanes_aligned, d1_valid == d3_valid, "divider lanes out of step")
  `TVA_ASSERT_ALWAYS(a_frac_den, !d2_valid || d2_den != '0 || d2_side.zero, "zero divisor not flagged")
  `TVA_ASSERT_NEXT(a_skid_fill, !k_valid && o_valid && !rsp.ready, k_valid, "stalled response dropped")
  `TVA_ASSERT_NEXT(a_skid_hold, k_valid && !rsp.ready, k_valid && $stable(k_res), "skid lost its response")
  `TVA_ASSERT_IMP(a_usec_range, rsp.valid, rsp.res_usec < USEC_W'(USEC_PER_SEC), "usec out of range")
  `TVA_ASSERT_IMP(a_divzero_clear, rsp.valid && rsp.status == ST_DIVZERO, rsp.res_sec == '0 && rsp.res_usec == '0, "div by zero result not clear")

endmodule
